// ----- src/epq_pkg.sv -----
// ---------------------------------------------------------------------------
// epq_pkg
// Shared types and codes for the expiring packet queue.
// ---------------------------------------------------------------------------
package epq_pkg;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_DEQD = 2'd2;
  localparam logic [1:0] CMD_FIND = 2'd3;

  localparam logic [2:0] K_ACCEPTED      = 3'd0;
  localparam logic [2:0] K_DELIVERED     = 3'd1;
  localparam logic [2:0] K_NONE          = 3'd2;
  localparam logic [2:0] K_PRESENT       = 3'd3;
  localparam logic [2:0] K_PURGED        = 3'd4;
  localparam logic [2:0] K_EVICT_FULL    = 3'd5;
  localparam logic [2:0] K_EVICT_TIMEOUT = 3'd6;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] expiry;
    logic [15:0] handle;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic        shift;   // cells at or above drop_pos take their upper neighbor
    logic        load;    // cell at count writes the new entry
    logic [31:0] now;
    logic [31:0] dest;
  } cell_ctl_t;

endpackage

// ----- src/epq_cell.sv -----
// ---------------------------------------------------------------------------
// epq_cell
// One queue slot: holds an entry, compares it, and takes its upper neighbor.
// ---------------------------------------------------------------------------
module epq_cell (
  input  logic           clk,
  input  logic           rst,
  input  epq_pkg::cell_ctl_t ctl,
  input  logic           below_drop, // this cell is below the dropped slot
  input  logic           is_tail,    // this cell is the append slot
  input  logic           up_valid,
  input  epq_pkg::entry_t up_entry,
  input  epq_pkg::entry_t new_entry,
  output logic           valid,
  output epq_pkg::entry_t entry,
  output logic           expired,
  output logic           match
);
  import epq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load && is_tail) begin
      valid <= 1'b1;
    end else if (ctl.shift && !below_drop) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && is_tail) begin
      entry <= new_entry;
    end else if (ctl.shift && !below_drop) begin
      entry <= up_entry;
    end
  end

  assign expired = valid && (entry.expiry < ctl.now);
  assign match   = valid && (entry.dest == ctl.dest);

endmodule

// ----- src/epq_seq.sv -----
// ---------------------------------------------------------------------------
// epq_seq
// Command sequencer: drives purge, eviction, removal and append steps.
// ---------------------------------------------------------------------------
module epq_seq #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_now,
  input  logic [31:0] in_dest,
  input  logic [15:0] in_handle,
  input  logic [31:0] expiry_timeout,
  input  logic [5:0]  queue_limit,
  input  logic [QUEUE_DEPTH-1:0] expired_v,
  input  logic [QUEUE_DEPTH-1:0] match_v,
  input  epq_pkg::entry_t cell_entry [QUEUE_DEPTH],
  output epq_pkg::cell_ctl_t ctl,
  output logic [QUEUE_DEPTH-1:0] below_drop,
  output logic [QUEUE_DEPTH-1:0] is_tail,
  output epq_pkg::entry_t new_entry,
  output logic        busy,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [2:0]  res_kind,
  output logic [15:0] res_handle,
  output logic [31:0] res_dest,
  output logic        res_last
);
  import epq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PURGE = 2'd1;
  localparam logic [1:0] S_ACT = 2'd2;

  logic [1:0]    state;
  logic [1:0]    cmd;
  logic [31:0]   now;
  logic [31:0]   dest;
  logic [15:0]   handle;
  logic [CW-1:0] count;
  logic [CW-1:0] lim;

  logic          any_exp, any_match;
  logic [IW-1:0] exp_pos, match_pos, drop_pos;
  logic          step_drop, step_load;
  logic          emit;
  logic [2:0]    emit_kind;
  entry_t        emit_entry;
  logic          emit_last;
  logic [32:0]   exp_sum;
  logic [CW-1:0] lim_next;

  always_comb begin
    any_exp = 1'b0;
    exp_pos = '0;
    any_match = 1'b0;
    match_pos = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (expired_v[i]) begin
        any_exp = 1'b1;
        exp_pos = IW'(i);
      end
      if (match_v[i]) begin
        any_match = 1'b1;
        match_pos = IW'(i);
      end
    end
  end

  always_comb begin
    if (queue_limit == 6'd0) begin
      lim_next = CW'(1);
    end else if ({26'd0, queue_limit} > 32'(QUEUE_DEPTH)) begin
      lim_next = CW'(QUEUE_DEPTH);
    end else begin
      lim_next = CW'(queue_limit);
    end
  end

  assign exp_sum = {1'b0, now} + {1'b0, expiry_timeout};
  assign new_entry = '{dest: dest, expiry: exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0],
                       handle: handle};

  // one step per cycle when the output register is free
  always_comb begin
    step_drop = 1'b0;
    step_load = 1'b0;
    emit = 1'b0;
    emit_kind = K_NONE;
    emit_entry = '0;
    emit_last = 1'b0;
    drop_pos = '0;
    if (!res_valid || res_ready) begin
      if (state == S_PURGE && any_exp) begin
        emit = 1'b1;
        step_drop = 1'b1;
        drop_pos = exp_pos;
        emit_kind = K_PURGED;
        emit_entry = cell_entry[exp_pos];
      end else if (state == S_PURGE || state == S_ACT) begin
        emit = 1'b1;
        emit_last = 1'b1;
        case (cmd)
          CMD_ENQ: begin
            if (count >= lim) begin
              emit_last = 1'b0;
              step_drop = 1'b1;
              emit_entry = cell_entry[0];
              emit_kind = (cell_entry[0].expiry > now) ? K_EVICT_FULL : K_EVICT_TIMEOUT;
            end else begin
              step_load = 1'b1;
              emit_kind = K_ACCEPTED;
            end
          end
          CMD_DEQ: begin
            if (count != '0) begin
              step_drop = 1'b1;
              emit_kind = K_DELIVERED;
              emit_entry = cell_entry[0];
            end
          end
          CMD_DEQD: begin
            if (any_match) begin
              step_drop = 1'b1;
              drop_pos = match_pos;
              emit_kind = K_DELIVERED;
              emit_entry = cell_entry[match_pos];
            end
          end
          default: begin
            emit_kind = any_match ? K_PRESENT : K_NONE;
          end
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      below_drop[i] = (IW'(i) < drop_pos);
      is_tail[i] = (CW'(i) == count);
    end
  end

  assign ctl = '{shift: step_drop, load: step_load, now: now, dest: dest};
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
        if (emit_last) state <= S_IDLE;
        else if (state == S_PURGE && !any_exp) state <= S_ACT;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (step_drop) count <= count - CW'(1);
      if (step_load) count <= count + CW'(1);
      if (in_fire) begin
        state <= (in_cmd == CMD_FIND) ? S_ACT : S_PURGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd <= in_cmd;
      now <= in_now;
      dest <= in_dest;
      handle <= in_handle;
      lim <= lim_next;
    end
    if (emit) begin
      res_kind <= emit_kind;
      res_handle <= emit_entry.handle;
      res_dest <= emit_entry.dest;
      res_last <= emit_last;
    end
  end

endmodule

// ----- src/expiring_packet_queue_by_destination.sv -----
// ---------------------------------------------------------------------------
// expiring_packet_queue_by_destination
// Route-wait packet queue built as a shifting row of entry cells.
// ---------------------------------------------------------------------------
// A request on s_axis (command in tuser; time, destination, handle in tdata)
// produces one or more results on m_axis (kind in tuser); tlast marks the
// final result of the request.
// Entries sit in a row of cells, oldest in cell 0; removing an entry shifts
// the cells above it down one place together.
// Each result is one step of the sequencer: a request with P purged and E
// evicted entries yields P + E + 1 results, the last with tlast. The next
// request is taken the cycle after the last result is registered. Results
// wait in an output register while m_axis_tready is low and the sequencer
// holds.
// Configuration writes (cfg_index 0 timeout, 1 limit) are taken any cycle.
// Reset empties the queue and restores timeout 30000 and limit 32.
// ---------------------------------------------------------------------------
module expiring_packet_queue_by_destination #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_time[31:0], dest_addr[63:32], packet_handle[79:64]
  input  logic [79:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_handle[15:0], out_dest[47:16]
  output logic [47:0] m_axis_tdata,
  // result_kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import epq_pkg::*;

  logic [31:0] expiry_timeout;
  logic [5:0]  queue_limit;
  logic        busy, in_fire;
  cell_ctl_t   ctl;
  logic [QUEUE_DEPTH-1:0] below_drop, is_tail, expired_v, match_v, valid_v;
  entry_t      cell_entry [QUEUE_DEPTH];
  entry_t      new_entry;
  logic [2:0]  res_kind;
  logic [15:0] res_handle;
  logic [31:0] res_dest;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_timeout <= 32'd30000;
      queue_limit <= 6'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT: expiry_timeout <= cfg_data;
        default:     queue_limit <= cfg_data[5:0];
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   up_v;
    entry_t up_e;
    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign up_v = 1'b0;
      assign up_e = cell_entry[i];
    end else begin : g_mid
      assign up_v = valid_v[i+1];
      assign up_e = cell_entry[i+1];
    end
    epq_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .below_drop(below_drop[i]), .is_tail(is_tail[i]),
      .up_valid(up_v), .up_entry(up_e), .new_entry(new_entry),
      .valid(valid_v[i]), .entry(cell_entry[i]),
      .expired(expired_v[i]), .match(match_v[i])
    );
  end

  epq_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .in_cmd(s_axis_tuser), .in_now(s_axis_tdata[31:0]),
    .in_dest(s_axis_tdata[63:32]), .in_handle(s_axis_tdata[79:64]),
    .expiry_timeout(expiry_timeout), .queue_limit(queue_limit),
    .expired_v(expired_v), .match_v(match_v), .cell_entry(cell_entry),
    .ctl(ctl), .below_drop(below_drop), .is_tail(is_tail), .new_entry(new_entry),
    .busy(busy), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_kind(res_kind), .res_handle(res_handle), .res_dest(res_dest),
    .res_last(m_axis_tlast)
  );

  assign m_axis_tdata = {res_dest, res_handle};
  assign m_axis_tuser = res_kind;

endmodule

// ----- bench/epq_checker.sv -----
// ---------------------------------------------------------------------------
// epq_checker
// Result predictor and scoreboard for the expiring packet queue.
// ---------------------------------------------------------------------------
// Watches the request, result and register channels. Each accepted request is
// run through a queue predictor of its own, which keeps the waiting packets
// oldest first. The expected results are then held in order and compared
// field by field with what leaves on m_axis.
// ---------------------------------------------------------------------------
module epq_checker #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  import epq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [31:0] dest;
    logic        last;
  } queue_result_t;

  logic [31:0]   wait_timeout;
  logic [5:0]    limit_reg;
  entry_t        waiting_pkts[$];
  queue_result_t due_results[$];
  queue_result_t batch[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic note(input logic [2:0] kind, input logic [15:0] handle,
                      input logic [31:0] dest);
    queue_result_t r;
    r.kind = kind;
    r.handle = handle;
    r.dest = dest;
    r.last = 1'b0;
    batch.push_back(r);
  endtask

  // drop every entry whose expiry is before now, oldest first
  task automatic purge_stale(input logic [31:0] now);
    int i;
    i = 0;
    while (i < waiting_pkts.size()) begin
      if (waiting_pkts[i].expiry < now) begin
        note(K_PURGED, waiting_pkts[i].handle, waiting_pkts[i].dest);
        waiting_pkts.delete(i);
      end else begin
        i++;
      end
    end
  endtask

  task automatic route_wait_apply(input logic [1:0] cmd, input logic [79:0] req);
    logic [31:0] now;
    logic [31:0] dest;
    logic [15:0] handle;
    logic [32:0] sum;
    int          lim;
    int          hit;
    entry_t      e;
    now = req[31:0];
    dest = req[63:32];
    handle = req[79:64];
    batch.delete();
    hit = -1;
    if (cmd == CMD_FIND) begin
      foreach (waiting_pkts[i])
        if (hit < 0 && waiting_pkts[i].dest == dest) hit = i;
      note(hit >= 0 ? K_PRESENT : K_NONE, '0, '0);
    end else begin
      purge_stale(now);
      case (cmd)
        CMD_ENQ: begin
          lim = (limit_reg == 0) ? 1 : (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : limit_reg;
          sum = {1'b0, now} + {1'b0, wait_timeout};
          while (waiting_pkts.size() >= lim) begin
            note(waiting_pkts[0].expiry > now ? K_EVICT_FULL : K_EVICT_TIMEOUT,
                 waiting_pkts[0].handle, waiting_pkts[0].dest);
            void'(waiting_pkts.pop_front());
          end
          e.dest = dest;
          e.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          e.handle = handle;
          waiting_pkts.push_back(e);
          note(K_ACCEPTED, '0, '0);
        end
        CMD_DEQ: begin
          if (waiting_pkts.size() > 0) begin
            note(K_DELIVERED, waiting_pkts[0].handle, waiting_pkts[0].dest);
            void'(waiting_pkts.pop_front());
          end else begin
            note(K_NONE, '0, '0);
          end
        end
        default: begin
          foreach (waiting_pkts[i])
            if (hit < 0 && waiting_pkts[i].dest == dest) hit = i;
          if (hit >= 0) begin
            note(K_DELIVERED, waiting_pkts[hit].handle, waiting_pkts[hit].dest);
            waiting_pkts.delete(hit);
          end else begin
            note(K_NONE, '0, '0);
          end
        end
      endcase
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) due_results.push_back(batch[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      wait_timeout <= 32'd30000;
      limit_reg <= 6'd32;
      waiting_pkts.delete();
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TIMEOUT) wait_timeout <= cfg_data;
        else limit_reg <= cfg_data[5:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected, data %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("result_kind", 32'(m_axis_tuser), 32'(want.kind));
          if (m_axis_tdata[15:0] !== want.handle)
            report_mismatch("out_handle", 32'(m_axis_tdata[15:0]), 32'(want.handle));
          if (m_axis_tdata[47:16] !== want.dest)
            report_mismatch("out_dest", m_axis_tdata[47:16], want.dest);
          if (m_axis_tlast !== want.last)
            report_mismatch("last_result", 32'(m_axis_tlast), 32'(want.last));
        end
      end
      // requests are predicted after this edge's results are consumed
      if (s_axis_tvalid && s_axis_tready) route_wait_apply(s_axis_tuser, s_axis_tdata);
    end
    pending = due_results.size();
  end

endmodule

// ----- bench/tb_expiring_packet_queue_by_destination.sv -----
// ---------------------------------------------------------------------------
// tb_expiring_packet_queue_by_destination
// Stimulus and verdict for the expiring packet queue.
// ---------------------------------------------------------------------------
// Drives a directed opening (empty queue, field extremes, find on stale
// entries, limit lowered below the entry count) and then random request mixes
// under several timeout and limit settings, ending near the top of the time
// range where the expiry saturates. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module tb_expiring_packet_queue_by_destination;
  import epq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_ENQ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_TIMEOUT;
  logic [31:0] cfg_data = '0;
  int          errors;
  int          pending;

  logic        calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  logic [31:0] clock_now = 32'd100;
  logic [31:0] cur_timeout = 32'd30000;
  logic [31:0] dest_pool[6];

  expiring_packet_queue_by_destination #(.QUEUE_DEPTH(32)) u_top (.*);

  epq_checker #(.QUEUE_DEPTH(32)) u_check (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(6, 25);
  endfunction

  // hold ready low for random stretches
  always @(posedge clk) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] dest,
                              input logic [15:0] handle);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {handle, dest, clock_now};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // write a register once every outstanding result has drained
  task automatic write_reg(input logic idx, input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TIMEOUT) cur_timeout = value;
  endtask

  task automatic advance(input logic [31:0] ticks);
    logic [32:0] t;
    t = {1'b0, clock_now} + ticks;
    clock_now = t[32] ? 32'hFFFF_FFFF : t[31:0];
  endtask

  function automatic logic [31:0] pick_dest();
    return ($urandom_range(0, 4) != 0) ? dest_pool[$urandom_range(0, 5)] : $urandom();
  endfunction

  task automatic random_run(input int count);
    int unsigned roll;
    logic [31:0] span;
    logic [1:0]  cmd;
    span = (cur_timeout > 4000) ? 32'd4000 : cur_timeout + 2;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      cmd = (roll < 45) ? CMD_ENQ : (roll < 65) ? CMD_DEQ : (roll < 85) ? CMD_DEQD : CMD_FIND;
      roll = $urandom_range(0, 29);
      if (roll < 20) advance($urandom_range(0, 2));
      else if (roll < 29) advance($urandom_range(0, span));
      else advance(cur_timeout > 40000 ? 32'd40000 : cur_timeout + 5);
      send_request(cmd, pick_dest(), 16'($urandom()));
    end
  endtask

  initial begin
    foreach (dest_pool[i]) dest_pool[i] = $urandom();
    dest_pool[0] = 32'h0000_0000;
    dest_pool[1] = 32'hFFFF_FFFF;
    @(negedge rst);
    @(posedge clk);

    // empty queue answers none
    calm = 1'b1;
    send_request(CMD_DEQ, 32'h0, 16'h0);
    send_request(CMD_DEQD, 32'hFFFF_FFFF, 16'h0);
    send_request(CMD_FIND, 32'h0, 16'h0);
    send_request(CMD_ENQ, 32'h0000_0000, 16'hFFFF);
    send_request(CMD_ENQ, 32'hFFFF_FFFF, 16'h0000);
    send_request(CMD_ENQ, dest_pool[2], 16'h5AA5);
    send_request(CMD_FIND, 32'hFFFF_FFFF, 16'h0);
    send_request(CMD_DEQD, 32'hFFFF_FFFF, 16'h0);
    send_request(CMD_DEQ, 32'h0, 16'h0);
    calm = 1'b0;
    // find still sees a stale entry; the next dequeue purges it
    advance(32'd30001);
    send_request(CMD_FIND, dest_pool[2], 16'h0);
    send_request(CMD_DEQ, 32'h0, 16'h0);
    // fill, then lower the limit under the count
    for (int i = 0; i < 12; i++) send_request(CMD_ENQ, pick_dest(), 16'($urandom()));
    write_reg(CFG_LIMIT, 32'd3);
    send_request(CMD_ENQ, pick_dest(), 16'h1234);
    advance(32'd10);
    send_request(CMD_ENQ, pick_dest(), 16'h4321);

    write_reg(CFG_LIMIT, 32'd32);
    random_run(80);
    write_reg(CFG_TIMEOUT, 32'd5);
    write_reg(CFG_LIMIT, 32'd4);
    random_run(50);
    write_reg(CFG_TIMEOUT, 32'd0);
    write_reg(CFG_LIMIT, 32'd1);
    random_run(35);
    write_reg(CFG_TIMEOUT, 32'd1);
    write_reg(CFG_LIMIT, 32'd0);
    random_run(30);
    calm = 1'b1;
    write_reg(CFG_TIMEOUT, 32'd50);
    write_reg(CFG_LIMIT, 32'd33);
    random_run(50);
    calm = 1'b0;
    write_reg(CFG_TIMEOUT, 32'd12);
    write_reg(CFG_LIMIT, 32'd63);
    random_run(40);
    // near the top of time, where arrival plus timeout saturates
    clock_now = 32'hFFFF_F000;
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_LIMIT, 32'd2);
    random_run(20);
    write_reg(CFG_TIMEOUT, 32'd1500);
    write_reg(CFG_LIMIT, 32'd6);
    random_run(25);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
